>>> rtl/sha512_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared constants, types and round functions of the SHA-512 stream hasher.
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [6:0] LenPosMax = 7'd111;  // last byte position that leaves room for length

  typedef logic [63:0] word_t;

  function automatic word_t round_const(input logic [6:0] r);
    word_t k;
    begin
      case (r)
        7'd0: k = 64'h428A2F98D728AE22; 7'd1: k = 64'h7137449123EF65CD;
        7'd2: k = 64'hB5C0FBCFEC4D3B2F; 7'd3: k = 64'hE9B5DBA58189DBBC;
        7'd4: k = 64'h3956C25BF348B538; 7'd5: k = 64'h59F111F1B605D019;
        7'd6: k = 64'h923F82A4AF194F9B; 7'd7: k = 64'hAB1C5ED5DA6D8118;
        7'd8: k = 64'hD807AA98A3030242; 7'd9: k = 64'h12835B0145706FBE;
        7'd10: k = 64'h243185BE4EE4B28C; 7'd11: k = 64'h550C7DC3D5FFB4E2;
        7'd12: k = 64'h72BE5D74F27B896F; 7'd13: k = 64'h80DEB1FE3B1696B1;
        7'd14: k = 64'h9BDC06A725C71235; 7'd15: k = 64'hC19BF174CF692694;
        7'd16: k = 64'hE49B69C19EF14AD2; 7'd17: k = 64'hEFBE4786384F25E3;
        7'd18: k = 64'h0FC19DC68B8CD5B5; 7'd19: k = 64'h240CA1CC77AC9C65;
        7'd20: k = 64'h2DE92C6F592B0275; 7'd21: k = 64'h4A7484AA6EA6E483;
        7'd22: k = 64'h5CB0A9DCBD41FBD4; 7'd23: k = 64'h76F988DA831153B5;
        7'd24: k = 64'h983E5152EE66DFAB; 7'd25: k = 64'hA831C66D2DB43210;
        7'd26: k = 64'hB00327C898FB213F; 7'd27: k = 64'hBF597FC7BEEF0EE4;
        7'd28: k = 64'hC6E00BF33DA88FC2; 7'd29: k = 64'hD5A79147930AA725;
        7'd30: k = 64'h06CA6351E003826F; 7'd31: k = 64'h142929670A0E6E70;
        7'd32: k = 64'h27B70A8546D22FFC; 7'd33: k = 64'h2E1B21385C26C926;
        7'd34: k = 64'h4D2C6DFC5AC42AED; 7'd35: k = 64'h53380D139D95B3DF;
        7'd36: k = 64'h650A73548BAF63DE; 7'd37: k = 64'h766A0ABB3C77B2A8;
        7'd38: k = 64'h81C2C92E47EDAEE6; 7'd39: k = 64'h92722C851482353B;
        7'd40: k = 64'hA2BFE8A14CF10364; 7'd41: k = 64'hA81A664BBC423001;
        7'd42: k = 64'hC24B8B70D0F89791; 7'd43: k = 64'hC76C51A30654BE30;
        7'd44: k = 64'hD192E819D6EF5218; 7'd45: k = 64'hD69906245565A910;
        7'd46: k = 64'hF40E35855771202A; 7'd47: k = 64'h106AA07032BBD1B8;
        7'd48: k = 64'h19A4C116B8D2D0C8; 7'd49: k = 64'h1E376C085141AB53;
        7'd50: k = 64'h2748774CDF8EEB99; 7'd51: k = 64'h34B0BCB5E19B48A8;
        7'd52: k = 64'h391C0CB3C5C95A63; 7'd53: k = 64'h4ED8AA4AE3418ACB;
        7'd54: k = 64'h5B9CCA4F7763E373; 7'd55: k = 64'h682E6FF3D6B2B8A3;
        7'd56: k = 64'h748F82EE5DEFB2FC; 7'd57: k = 64'h78A5636F43172F60;
        7'd58: k = 64'h84C87814A1F0AB72; 7'd59: k = 64'h8CC702081A6439EC;
        7'd60: k = 64'h90BEFFFA23631E28; 7'd61: k = 64'hA4506CEBDE82BDE9;
        7'd62: k = 64'hBEF9A3F7B2C67915; 7'd63: k = 64'hC67178F2E372532B;
        7'd64: k = 64'hCA273ECEEA26619C; 7'd65: k = 64'hD186B8C721C0C207;
        7'd66: k = 64'hEADA7DD6CDE0EB1E; 7'd67: k = 64'hF57D4F7FEE6ED178;
        7'd68: k = 64'h06F067AA72176FBA; 7'd69: k = 64'h0A637DC5A2C898A6;
        7'd70: k = 64'h113F9804BEF90DAE; 7'd71: k = 64'h1B710B35131C471B;
        7'd72: k = 64'h28DB77F523047D84; 7'd73: k = 64'h32CAAB7B40C72493;
        7'd74: k = 64'h3C9EBE0A15C9BEBC; 7'd75: k = 64'h431D67C49C100D4C;
        7'd76: k = 64'h4CC5D4BECB3E42B6; 7'd77: k = 64'h597F299CFC657E2A;
        7'd78: k = 64'h5FCB6FAB3AD6FAEC; 7'd79: k = 64'h6C44198C4A475817;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    begin
      case (i)
        3'd0: h = 64'h6A09E667F3BCC908; 3'd1: h = 64'hBB67AE8584CAA73B;
        3'd2: h = 64'h3C6EF372FE94F82B; 3'd3: h = 64'hA54FF53A5F1D36F1;
        3'd4: h = 64'h510E527FADE682D1; 3'd5: h = 64'h9B05688C2B3E6C1F;
        3'd6: h = 64'h1F83D9ABFB41BD6B; 3'd7: h = 64'h5BE0CD19137E2179;
        default: h = '0;
      endcase
      return h;
    end
  endfunction

  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

endpackage
`default_nettype wire

>>> rtl/sha512_round_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha512_round_core
// 80-round compression of one block held in the 16-word block RAM. The
// message schedule is rewritten in place in a schedule RAM, one word per
// round from round 16 on, after the block is copied there. Chaining hash
// lives in a small 8-word RAM read/written one word per cycle during finalize.
// ----------------------------------------------------------------------------
module sha512_round_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,      // block RAM is complete
  input  wire logic                   hash_init,  // reload initial hash values
  output logic                        busy,
  // block RAM read port (owned while busy)
  output logic [3:0]                  blk_raddr,
  input  wire sha512_pkg::word_t      blk_rdata,
  // digest readout
  input  wire logic [2:0]             hash_raddr,
  output sha512_pkg::word_t           hash_rdata
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_SCHED = 5'b00100,
    S_ROUND = 5'b01000,
    S_FIN   = 5'b10000
  } st_t;

  st_t st;
  logic [6:0] cnt;
  logic [3:0] sub;  // sub-step within a scheduled round

  // schedule RAM: four reads per scheduled round taken in sub-steps
  sha512_pkg::word_t sched_mem [16];
  logic [3:0] s_raddr;
  sha512_pkg::word_t s_rdata;
  logic s_we;
  logic [3:0] s_waddr;
  sha512_pkg::word_t s_wdata;

  always_ff @(posedge clk) begin
    if (s_we) sched_mem[s_waddr] <= s_wdata;
    s_rdata <= sched_mem[s_raddr];
  end

  // chaining hash RAM
  sha512_pkg::word_t hash_mem [8];
  logic [2:0] h_raddr;
  sha512_pkg::word_t h_rdata;
  logic h_we;
  logic [2:0] h_waddr;
  sha512_pkg::word_t h_wdata;
  logic [3:0] init_cnt;

  always_ff @(posedge clk) begin
    if (h_we) hash_mem[h_waddr] <= h_wdata;
    h_rdata <= hash_mem[h_raddr];
  end

  sha512_pkg::word_t a, b, c, d, e, f, g, h;
  sha512_pkg::word_t x0, x1, x9, w, wreg;

  // round logic
  sha512_pkg::word_t t1, t2, s0, s1;
  always_comb begin
    t1 = h + (sha512_pkg::rotr(e, 14) ^ sha512_pkg::rotr(e, 18) ^ sha512_pkg::rotr(e, 41))
         + ((e & f) ^ (~e & g)) + sha512_pkg::round_const(cnt) + wreg;
    t2 = (sha512_pkg::rotr(a, 28) ^ sha512_pkg::rotr(a, 34) ^ sha512_pkg::rotr(a, 39))
         + ((a & b) ^ (a & c) ^ (b & c));
    s0 = sha512_pkg::rotr(x1, 1) ^ sha512_pkg::rotr(x1, 8) ^ (x1 >> 7);
    s1 = sha512_pkg::rotr(s_rdata, 19) ^ sha512_pkg::rotr(s_rdata, 61) ^ (s_rdata >> 6);
    w  = x0 + s0 + x9 + s1;
  end

  assign busy = (st != S_IDLE) || (init_cnt != 4'd8);
  assign hash_rdata = h_rdata;

  // address selection
  always_comb begin
    blk_raddr = cnt[3:0];
    s_raddr = 4'd0;
    h_raddr = hash_raddr;
    s_we = 1'b0;
    s_waddr = cnt[3:0];
    s_wdata = blk_rdata;
    h_we = 1'b0;
    h_waddr = init_cnt[2:0];
    h_wdata = sha512_pkg::init_hash(init_cnt[2:0]);
    if (init_cnt != 4'd8) begin
      h_we = 1'b1;
    end
    case (st)
      S_LOAD: begin
        // blk read of cnt issued last cycle; write it at cnt-1
        s_we = (sub != 4'd0);
        s_waddr = cnt[3:0] - 4'd1;
        h_raddr = cnt[2:0];
      end
      S_SCHED: begin
        case (sub)
          4'd0: s_raddr = cnt[3:0];
          4'd1: s_raddr = cnt[3:0] + 4'd1;
          4'd2: s_raddr = cnt[3:0] + 4'd9;
          4'd3: s_raddr = cnt[3:0] + 4'd14;
          default: s_raddr = cnt[3:0];
        endcase
        s_we = (sub == 4'd4);
        s_waddr = cnt[3:0];
        s_wdata = w;
      end
      S_ROUND: s_raddr = cnt[3:0];
      S_FIN: begin
        h_raddr = sub[2:0];
        h_we = (sub != 4'd0);
        h_waddr = sub[2:0] - 3'd1;
        case (h_waddr)
          3'd0: h_wdata = h_rdata + a;
          3'd1: h_wdata = h_rdata + b;
          3'd2: h_wdata = h_rdata + c;
          3'd3: h_wdata = h_rdata + d;
          3'd4: h_wdata = h_rdata + e;
          3'd5: h_wdata = h_rdata + f;
          3'd6: h_wdata = h_rdata + g;
          default: h_wdata = h_rdata + h;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      cnt <= '0;
      sub <= '0;
      init_cnt <= '0;
    end else begin
      if (hash_init) init_cnt <= '0;
      else if (init_cnt != 4'd8) init_cnt <= init_cnt + 4'd1;
      case (st)
        S_IDLE: begin
          if (start) begin
            st <= S_LOAD;
            cnt <= '0;
            sub <= '0;
          end
        end
        S_LOAD: begin
          // cnt 0..16 issues block reads; hash words captured for a..h
          sub <= 4'd1;
          if (cnt >= 7'd1 && cnt <= 7'd8) begin
            case (cnt[3:0])
              4'd1: a <= h_rdata; 4'd2: b <= h_rdata; 4'd3: c <= h_rdata;
              4'd4: d <= h_rdata; 4'd5: e <= h_rdata; 4'd6: f <= h_rdata;
              4'd7: g <= h_rdata; default: h <= h_rdata;
            endcase
          end
          if (cnt == 7'd16) begin
            st <= S_ROUND;
            cnt <= '0;
            sub <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_ROUND: begin
          // rounds below 16 read the word straight; otherwise come via S_SCHED
          if (sub == 4'd0) begin
            sub <= 4'd1;
          end else begin
            sub <= '0;
            wreg <= s_rdata;
            st <= S_SCHED;  // apply step in S_SCHED below
          end
        end
        S_SCHED: begin
          if (cnt < 7'd16) begin
            // apply round with wreg
            h <= g; g <= f; f <= e; e <= d + t1;
            d <= c; c <= b; b <= a; a <= t1 + t2;
            cnt <= cnt + 7'd1;
            sub <= '0;
            st <= (cnt == 7'd15) ? S_SCHED : S_ROUND;
          end else if (sub == 4'd5) begin
            h <= g; g <= f; f <= e; e <= d + t1;
            d <= c; c <= b; b <= a; a <= t1 + t2;
            sub <= '0;
            if (cnt == 7'd79) begin
              st <= S_FIN;
            end else begin
              cnt <= cnt + 7'd1;
            end
          end else begin
            sub <= sub + 4'd1;
            case (sub)
              4'd1: x0 <= s_rdata;
              4'd2: x1 <= s_rdata;
              4'd3: x9 <= s_rdata;
              4'd4: wreg <= w;  // s_rdata holds word r+14 here
              default: ;
            endcase
          end
        end
        S_FIN: begin
          if (sub == 4'd8) begin
            st <= S_IDLE;
            sub <= '0;
            cnt <= '0;
          end else begin
            sub <= sub + 4'd1;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/sha512_stream_hasher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha512_stream_hasher
// Byte-serial SHA-512 engine: packs bytes into a block RAM, pads at end of
// message and streams the eight digest words out.
// ----------------------------------------------------------------------------
// Input channel: data_byte / byte_valid / end_of_message with in_valid and
// in_stall. Output channel: digest_word / word_index / last_word with
// out_valid and out_stall; one transaction per digest word, index 0 first.
// A byte that does not fill a block is merged into its block RAM word by
// read-modify-write. Filling a block starts the round core, which reads
// each schedule word from its RAM one port access at a time: it loads the
// block, runs the early and the later rounds and then folds the hash;
// in_stall stays high meanwhile. End of message adds one or two such
// blocks plus a padding sweep, then eight output transactions. Reset
// (rst, synchronous) reloads the initial hash and clears the byte count;
// the block RAM is not cleared. A stalled output holds its word and index;
// no new input is taken until the digest is drained.
// ----------------------------------------------------------------------------
module sha512_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_BYTE  = 8'b00000010,
    S_PADW  = 8'b00000100,
    S_COMP  = 8'b00001000,
    S_LEN   = 8'b00010000,
    S_OUTRD = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_WAIT  = 8'b10000000
  } st_t;

  st_t st;
  logic [63:0] msg_len;
  logic        eom_pend, len_done;
  logic [7:0]  byte_q;
  logic [4:0]  pad_idx;
  logic [3:0]  out_idx;
  // pad bookkeeping: pad byte goes in without counting; pad_full marks that
  // the length words did not fit behind it
  logic        byte_valid_q, pad_phase, pad_full;

  // block RAM
  sha512_pkg::word_t blk_mem [16];
  logic              b_we;
  logic [3:0]        b_waddr, b_raddr, core_raddr;
  sha512_pkg::word_t b_wdata, b_rdata;

  always_ff @(posedge clk) begin
    if (b_we) blk_mem[b_waddr] <= b_wdata;
    b_rdata <= blk_mem[b_raddr];
  end

  logic core_start, core_busy;
  logic hash_init;
  sha512_pkg::word_t hash_rdata;

  sha512_round_core u_core (
    .clk(clk), .rst(rst), .start(core_start), .hash_init(hash_init),
    .busy(core_busy), .blk_raddr(core_raddr), .blk_rdata(b_rdata),
    .hash_raddr(out_idx[2:0]), .hash_rdata(hash_rdata)
  );

  logic [6:0] pos;
  logic [2:0] lane;
  logic [5:0] sh;
  assign pos  = msg_len[6:0];
  assign lane = pos[2:0];
  assign sh   = 6'd56 - {lane, 3'b000};

  sha512_pkg::word_t keep_mask, merged;
  always_comb begin
    // a pad byte also clears the lanes behind it
    keep_mask = byte_valid_q ? ~(64'hFF << sh) : (64'hFFFF_FFFF_FFFF_FF00 << sh);
    merged = (b_rdata & keep_mask) | ({56'd0, byte_q} << sh);
  end

  assign in_stall = (st != S_IDLE) || core_busy;

  always_comb begin
    b_we = 1'b0;
    b_waddr = pos[6:3];
    b_wdata = merged;
    b_raddr = (st == S_COMP) ? core_raddr : pos[6:3];
    case (st)
      S_BYTE: b_we = 1'b1;
      S_PADW: begin
        b_we = !pad_idx[4];
        b_waddr = pad_idx[3:0];
        b_wdata = '0;
      end
      S_LEN: begin
        b_we = 1'b1;
        b_waddr = pad_idx[3:0];
        b_wdata = (pad_idx[0]) ? {msg_len[60:0], 3'b000} : {61'd0, msg_len[63:61]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      msg_len <= '0;
      eom_pend <= 1'b0;
      len_done <= 1'b0;
      core_start <= 1'b0;
      hash_init <= 1'b1;
      out_valid <= 1'b0;
      out_idx <= '0;
      pad_idx <= '0;
      byte_valid_q <= 1'b1;
      pad_phase <= 1'b0;
      pad_full <= 1'b0;
    end else begin
      core_start <= 1'b0;
      hash_init <= 1'b0;
      case (st)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            eom_pend <= end_of_message;
            len_done <= 1'b0;
            byte_valid_q <= byte_valid;
            pad_phase <= 1'b0;
            pad_full <= 1'b0;
            if (byte_valid) begin
              byte_q <= data_byte;
              st <= S_BYTE;
            end else if (end_of_message) begin
              byte_q <= sha512_pkg::PadByte;
              st <= S_BYTE;
            end
          end
        end
        S_BYTE: begin
          // merged byte written this cycle at pos
          pad_idx <= {1'b0, pos[6:3]} + 5'd1;
          if (eom_pend && byte_q == sha512_pkg::PadByte && !byte_valid_q) begin
            pad_full <= (pos > sha512_pkg::LenPosMax);
            st <= S_PADW;
          end else begin
            msg_len <= msg_len + 64'd1;
            if (pos == 7'd127) begin
              core_start <= 1'b1;
              st <= S_COMP;
            end else if (eom_pend) begin
              byte_q <= sha512_pkg::PadByte;
              byte_valid_q <= 1'b0;
              st <= S_WAIT;
            end else begin
              st <= S_IDLE;
            end
          end
        end
        S_WAIT: st <= S_BYTE;  // block RAM read of the pad word
        S_COMP: begin
          if (!core_start && !core_busy) begin
            if (eom_pend && len_done) begin
              out_idx <= '0;
              st <= S_OUTRD;
            end else if (eom_pend && pad_phase) begin
              pad_idx <= '0;
              pad_phase <= 1'b0;
              st <= S_PADW;
            end else if (eom_pend) begin
              byte_q <= sha512_pkg::PadByte;
              byte_valid_q <= 1'b0;
              st <= S_WAIT;
            end else begin
              st <= S_IDLE;
            end
          end
        end
        S_PADW: begin
          if (pad_idx == 5'd14 && !pad_full) begin
            st <= S_LEN;
          end else if (pad_idx == 5'd16) begin
            core_start <= 1'b1;
            pad_phase <= 1'b1;
            pad_full <= 1'b0;
            st <= S_COMP;
          end else begin
            pad_idx <= pad_idx + 5'd1;
          end
        end
        S_LEN: begin
          if (pad_idx == 5'd15) begin
            core_start <= 1'b1;
            len_done <= 1'b1;
            st <= S_COMP;
          end else begin
            pad_idx <= pad_idx + 5'd1;
          end
        end
        S_OUTRD: begin
          out_valid <= 1'b1;
          st <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (out_idx == 4'd7) begin
              out_valid <= 1'b0;
              msg_len <= '0;
              hash_init <= 1'b1;
              eom_pend <= 1'b0;
              st <= S_IDLE;
            end else begin
              out_valid <= 1'b0;
              out_idx <= out_idx + 4'd1;
              st <= S_OUTRD;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign digest_word = hash_rdata;
  assign word_index  = out_idx[2:0];
  assign last_word   = (out_idx == 4'd7);

endmodule
`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// sha512_stream_hasher testbench
// Streams byte messages through the hasher under random valid/stall gaps and
// checks every digest word against a SHA-512 predictor kept in this bench.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } byte_item_t;

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_out_t;

  localparam int unsigned Limit = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = '0;
  logic byte_valid = 1'b0;
  logic end_of_message = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [63:0] digest_word;
  logic [2:0] word_index;
  logic last_word;

  byte_item_t pending_bytes[$];
  digest_out_t expected_digests[$];
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 63;
  int unsigned hold_off = 0;

  // predictor state
  logic [63:0] chain[8];
  logic [63:0] blk[16];
  logic [63:0] byte_count;

  sha512_stream_hasher u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .byte_valid(byte_valid), .end_of_message(end_of_message),
    .out_valid(out_valid), .out_stall(out_stall), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word)
  );

  always #4 clk = ~clk;

  localparam logic [63:0] KTab[80] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
    64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
    64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
    64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
    64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
    64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
    64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
    64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
    64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
    64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
    64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
    64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
    64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
    64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};

  localparam logic [63:0] IvTab[8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};

  function automatic logic [63:0] ror(logic [63:0] v, int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  task automatic compress();
    logic [63:0] w[16];
    logic [63:0] v[8];
    logic [63:0] wr, t1, t2, x1, x14;
    for (int k = 0; k < 16; k++) w[k] = blk[k];
    for (int k = 0; k < 8; k++) v[k] = chain[k];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        x1 = w[(r + 1) % 16];
        x14 = w[(r + 14) % 16];
        wr = w[r % 16] + (ror(x1, 1) ^ ror(x1, 8) ^ (x1 >> 7)) + w[(r + 9) % 16]
             + (ror(x14, 19) ^ ror(x14, 61) ^ (x14 >> 6));
        w[r % 16] = wr;
      end
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[r] + wr;
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int k = 7; k > 0; k--) v[k] = v[k - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++) chain[k] = chain[k] + v[k];
  endtask

  task automatic place_byte(int pos, logic [7:0] b);
    blk[pos / 8][63 - 8 * (pos % 8) -: 8] = b;
  endtask

  task automatic hash_item(byte_item_t it);
    int pos;
    digest_out_t d;
    if (it.has_byte) begin
      pos = int'(byte_count[6:0]);
      place_byte(pos, it.data);
      byte_count = byte_count + 1;
      if (pos == 127) compress();
    end
    if (it.eom) begin
      pos = int'(byte_count[6:0]);
      place_byte(pos, sha512_pkg::PadByte);
      for (int k = pos + 1; k < 128; k++) place_byte(k, 8'h00);
      if (pos >= 112) begin
        compress();
        for (int k = 0; k < 16; k++) blk[k] = '0;
      end
      blk[14] = byte_count >> 61;
      blk[15] = byte_count << 3;
      compress();
      for (int k = 0; k < 8; k++) begin
        d.word = chain[k];
        d.idx = k[2:0];
        d.last = (k == 7);
        expected_digests.push_back(d);
      end
      for (int k = 0; k < 8; k++) chain[k] = IvTab[k];
      byte_count = '0;
    end
  endtask

  task automatic queue_message(int len, int mode);
    byte_item_t it;
    bit ended;
    ended = 1'b0;
    for (int i = 0; i < len; i++) begin
      it.data = (mode == 1) ? 8'hFF : (mode == 2) ? 8'h00 : 8'($urandom_range(0, 255));
      it.has_byte = 1'b1;
      // end rides on the last byte half the time, otherwise a separate empty item
      it.eom = (i == len - 1) && ($urandom_range(0, 1) == 1);
      ended = it.eom;
      pending_bytes.push_back(it);
      if (!ended && $urandom_range(0, 9) == 0) begin
        it.data = 8'($urandom_range(0, 255));
        it.has_byte = 1'b0;
        it.eom = 1'b0;
        pending_bytes.push_back(it);
      end
    end
    if (!ended) begin
      it.data = 8'($urandom_range(0, 255));
      it.has_byte = 1'b0;
      it.eom = 1'b1;
      pending_bytes.push_back(it);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
          byte_item_t it;
          it = pending_bytes.pop_front();
          hash_item(it);
          in_valid <= 1'b1;
          data_byte <= it.data;
          byte_valid <= it.has_byte;
          end_of_message <= it.eom;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall and monitor
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_digests.size() == 0) begin
        $error("digest word with none expected: %h", digest_word);
        failures++;
      end else begin
        digest_out_t e;
        e = expected_digests.pop_front();
        if (digest_word !== e.word) begin
          $error("digest_word expected %h actual %h", e.word, digest_word);
          failures++;
        end
        if (word_index !== e.idx) begin
          $error("word_index expected %0d actual %0d", e.idx, word_index);
          failures++;
        end
        if (last_word !== e.last) begin
          $error("last_word expected %0d actual %0d", e.last, last_word);
          failures++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(1, 100) <= recv_idle_pct);
    end
    if (cycle_count > Limit) begin
      $display("[sha512_stream_hasher] ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid || expected_digests.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    for (int k = 0; k < 8; k++) chain[k] = IvTab[k];
    for (int k = 0; k < 16; k++) blk[k] = '0;
    byte_count = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message, all-ones and all-zero bytes, length past the
    // pad slot, exactly one full block
    queue_message(0, 0);
    queue_message(1, 1);
    queue_message(2, 2);
    queue_message(127, 0);
    queue_message(128, 1);
    for (int m = 0; m < 3; m++) queue_message($urandom_range(0, 16), 0);
    wait_drained();

    // idle ratios swapped, with a long receiver hold-off under load
    send_idle_pct = 63;
    recv_idle_pct = 19;
    hold_off = 3000;
    queue_message(12, 0);
    queue_message(4, 0);
    for (int m = 0; m < 3; m++) queue_message($urandom_range(0, 16), 0);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int m = 0; m < 3; m++) queue_message($urandom_range(0, 16), 0);
    wait_drained();
    repeat (50) @(posedge clk);

    if (failures == 0 && expected_digests.size() == 0) begin
      $display("[sha512_stream_hasher] OK");
    end else begin
      $display("[sha512_stream_hasher] ERROR");
    end
    $finish;
  end
endmodule
